// ===== sv/pds_pkg.sv =====
// Package for the packed document boundary scanner.
// Holds widths, limits, register indexes and the record type passed from front to back.
// No dependencies.
package pds_pkg;

	localparam int unsigned POS_W = 32;
	localparam int unsigned ROW_W = 17;
	localparam int unsigned TOK_W = 21;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 17;

	localparam logic [ROW_W-1:0] MAX_ROW = 17'd65536;
	localparam logic [TOK_W-1:0] MAX_TOKENS = 21'd1048576;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MULTIMODAL = 2'd1;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	// One classified token: up to two documents closed by it.
	typedef struct packed {
		logic             brk;
		logic             close;
		logic             fin;
		logic [TOK_W-1:0] end1;
		logic [ROW_W-1:0] len1;
		logic [TOK_W-1:0] end2;
		logic [ROW_W-1:0] len2;
	} close_rec_t;

endpackage

// ===== sv/pds_if.sv =====
// Channel interfaces for the packed document boundary scanner.
// Depends on pds_pkg for field widths.
interface pds_token_if;
	logic                          valid;
	logic                          ready;
	logic [pds_pkg::POS_W-1:0]     position_id;
	logic                          batch_end;

	modport source (output valid, position_id, batch_end, input ready);
	modport sink (input valid, position_id, batch_end, output ready);
endinterface

interface pds_result_if;
	logic                          valid;
	logic                          ready;
	logic [pds_pkg::TOK_W-1:0]     end_offset;
	logic [pds_pkg::ROW_W-1:0]     doc_length;
	logic [pds_pkg::ROW_W-1:0]     longest_so_far;
	logic [pds_pkg::TOK_W-1:0]     doc_count;
	logic                          boundary_seen;
	logic                          final_result;

	modport source (output valid, end_offset, doc_length, longest_so_far, doc_count,
		boundary_seen, final_result, input ready);
	modport sink (input valid, end_offset, doc_length, longest_so_far, doc_count,
		boundary_seen, final_result, output ready);
endinterface

// ===== sv/packed_document_boundary_scanner.sv =====
// Top level of the packed document boundary scanner.
// Depends on pds_pkg, the channel interfaces, pds_front, pds_queue and pds_back.
//
// Usage: the position IDs of a packed batch enter on the tokens channel, one
// transaction per token, row after row; batch_end marks the last token of the batch.
// Each document that closes (at an in-row boundary or at a row end) leaves as one
// transaction on the results channel. A token can close two documents; then the
// boundary result comes first and the row-end result second.
// Configuration goes through the write port: index 0 is row_length, index 1 is
// multimodal_mode. Writes are to be taken only while no token is in flight; the user must
// ensure this, as the block does not enforce it. A token's records pass through the record
// queue into the output register. Throughput: one token per cycle while the queue is not
// full. The output register moves one result per cycle while the receiver is ready, so a
// token that closes two documents gives two output transfers; the four-entry record queue
// between front and back absorbs such bursts. When the receiver stalls, the output register
// holds, the queue fills, and tokens.ready drops once it is full. Reset clears all batch
// state, sets row_length to one and multimodal_mode to zero, and empties the queue and the output register.
module packed_document_boundary_scanner (
	input  logic                           clk,
	input  logic                           arst_n,
	pds_token_if.sink                      tokens,
	pds_result_if.source                   results,
	input  logic                           wr_en,
	input  logic [pds_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pds_pkg::CFG_DATA_W-1:0] wr_data
);

	logic                push;
	logic                pop;
	logic                take;
	logic                not_empty;
	logic                full;
	pds_pkg::close_rec_t front_rec;
	pds_pkg::close_rec_t head_rec;

	// The front only stalls when the record queue has no room.
	assign tokens.ready = !full;
	assign take         = tokens.valid && !full;

	pds_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.take        (take),
		.position_id (tokens.position_id),
		.batch_end   (tokens.batch_end),
		.push        (push),
		.rec         (front_rec)
	);

	pds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_rec  (front_rec),
		.pop       (pop),
		.head_rec  (head_rec),
		.not_empty (not_empty),
		.full      (full)
	);

	pds_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_rec   (head_rec),
		.head_valid (not_empty),
		.pop        (pop),
		.results    (results)
	);

endmodule

// ===== sv/pds_front.sv =====
// Front of the scanner: configuration registers, boundary detection and row tracking.
// Depends on pds_pkg; emits close_rec_t records toward the queue.
module pds_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pds_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [pds_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                           take,
	input  logic [pds_pkg::POS_W-1:0]      position_id,
	input  logic                           batch_end,
	output logic                           push,
	output pds_pkg::close_rec_t            rec
);

	logic [pds_pkg::ROW_W-1:0] row_length_q;
	logic                      multimodal_q;
	logic [pds_pkg::POS_W-1:0] prev_pos_q;
	logic [pds_pkg::ROW_W-1:0] column_q;
	logic [pds_pkg::ROW_W-1:0] doc_start_q;
	logic [pds_pkg::TOK_W-1:0] tokens_q;

	logic [pds_pkg::ROW_W-1:0] row_eff;
	logic [pds_pkg::POS_W:0]   step;
	logic                      brk;
	logic [pds_pkg::ROW_W-1:0] col_next;
	logic [pds_pkg::ROW_W-1:0] start_after;
	logic [pds_pkg::TOK_W-1:0] tokens_next;
	logic                      close;

	always_comb begin
		if (row_length_q == '0) begin
			row_eff = pds_pkg::ROW_W'(1);
		end else if (row_length_q > pds_pkg::MAX_ROW) begin
			row_eff = pds_pkg::MAX_ROW;
		end else begin
			row_eff = row_length_q;
		end
	end

	// The step is taken one bit wider than the positions, so it never wraps.
	assign step = {position_id[pds_pkg::POS_W-1], position_id}
		- {prev_pos_q[pds_pkg::POS_W-1], prev_pos_q};

	always_comb begin
		if (column_q == '0) begin
			brk = 1'b0;
		end else if (multimodal_q) begin
			brk = $signed(position_id) < $signed(prev_pos_q);
		end else begin
			brk = step != (pds_pkg::POS_W+1)'(1);
		end
	end

	assign col_next    = column_q + pds_pkg::ROW_W'(1);
	assign start_after = brk ? column_q : doc_start_q;
	assign tokens_next = (tokens_q < pds_pkg::MAX_TOKENS) ? tokens_q + pds_pkg::TOK_W'(1)
		: tokens_q;
	assign close       = (col_next >= row_eff) || batch_end;

	assign push       = take && (brk || close);
	assign rec.brk    = brk;
	assign rec.close  = close;
	assign rec.fin    = batch_end;
	assign rec.end1   = tokens_q;
	assign rec.len1   = column_q - doc_start_q;
	assign rec.end2   = tokens_next;
	assign rec.len2   = col_next - start_after;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= pds_pkg::ROW_W'(1);
			multimodal_q <= 1'b0;
		end else if (wr_en) begin
			if (wr_index == pds_pkg::REG_ROW_LENGTH) begin
				row_length_q <= wr_data[pds_pkg::ROW_W-1:0];
			end else if (wr_index == pds_pkg::REG_MULTIMODAL) begin
				multimodal_q <= wr_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pos_q  <= '0;
			column_q    <= '0;
			doc_start_q <= '0;
			tokens_q    <= '0;
		end else if (take) begin
			prev_pos_q <= batch_end ? '0 : position_id;
			tokens_q   <= batch_end ? '0 : tokens_next;
			if (close) begin
				column_q    <= '0;
				doc_start_q <= '0;
			end else begin
				column_q    <= col_next;
				doc_start_q <= start_after;
			end
		end
	end

endmodule

// ===== sv/pds_queue.sv =====
// Short register queue of close records between front and back.
// Depends on pds_pkg for the record type and depth.
module pds_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  pds_pkg::close_rec_t push_rec,
	input  logic                pop,
	output pds_pkg::close_rec_t head_rec,
	output logic                not_empty,
	output logic                full
);

	pds_pkg::close_rec_t        slots_q [pds_pkg::QDEPTH];
	logic [pds_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [pds_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [pds_pkg::QCNT_W-1:0] count_q;
	logic                       do_pop;

	assign not_empty = count_q != '0;
	assign full      = count_q == pds_pkg::QCNT_W'(pds_pkg::QDEPTH);
	assign head_rec  = slots_q[rd_ptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + pds_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + pds_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				count_q <= count_q + pds_pkg::QCNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - pds_pkg::QCNT_W'(1);
			end
		end
	end

endmodule

// ===== sv/pds_back.sv =====
// Back of the scanner: running maximum, document count and the output register.
// Depends on pds_pkg and the result interface.
module pds_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pds_pkg::close_rec_t head_rec,
	input  logic                head_valid,
	output logic                pop,
	pds_result_if.source        results
);

	logic                      out_valid_q;
	logic [pds_pkg::TOK_W-1:0] end_offset_q;
	logic [pds_pkg::ROW_W-1:0] doc_length_q;
	logic [pds_pkg::ROW_W-1:0] longest_out_q;
	logic [pds_pkg::TOK_W-1:0] doc_count_out_q;
	logic                      boundary_out_q;
	logic                      final_out_q;

	logic                      second_q;
	logic [pds_pkg::ROW_W-1:0] longest_q;
	logic [pds_pkg::TOK_W-1:0] docs_q;
	logic                      any_boundary_q;

	logic                      emit;
	logic                      cur_brk;
	logic [pds_pkg::TOK_W-1:0] cur_end;
	logic [pds_pkg::ROW_W-1:0] cur_len;
	logic [pds_pkg::ROW_W-1:0] longest_next;
	logic [pds_pkg::TOK_W-1:0] docs_next;
	logic                      boundary_next;
	logic                      last_of_rec;

	assign emit    = head_valid && (!out_valid_q || results.ready);
	// A boundary result goes out before the row-end result of the same token.
	assign cur_brk = head_rec.brk && !second_q;
	assign cur_end = cur_brk ? head_rec.end1 : head_rec.end2;
	assign cur_len = cur_brk ? head_rec.len1 : head_rec.len2;

	assign longest_next  = (cur_len > longest_q) ? cur_len : longest_q;
	assign docs_next     = (docs_q < pds_pkg::MAX_TOKENS) ? docs_q + pds_pkg::TOK_W'(1) : docs_q;
	assign boundary_next = any_boundary_q || cur_brk;
	assign last_of_rec   = !(cur_brk && head_rec.close);
	assign pop           = emit && last_of_rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			second_q       <= 1'b0;
			longest_q      <= '0;
			docs_q         <= '0;
			any_boundary_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				second_q    <= !last_of_rec;
				if (!cur_brk && head_rec.fin) begin
					longest_q      <= '0;
					docs_q         <= '0;
					any_boundary_q <= 1'b0;
				end else begin
					longest_q      <= longest_next;
					docs_q         <= docs_next;
					any_boundary_q <= boundary_next;
				end
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			end_offset_q    <= cur_end;
			doc_length_q    <= cur_len;
			longest_out_q   <= longest_next;
			doc_count_out_q <= docs_next;
			boundary_out_q  <= boundary_next;
			final_out_q     <= !cur_brk && head_rec.fin;
		end
	end

	assign results.valid          = out_valid_q;
	assign results.end_offset     = end_offset_q;
	assign results.doc_length     = doc_length_q;
	assign results.longest_so_far = longest_out_q;
	assign results.doc_count      = doc_count_out_q;
	assign results.boundary_seen  = boundary_out_q;
	assign results.final_result   = final_out_q;

endmodule

// ===== test/tb_top.sv =====
// Testbench for packed_document_boundary_scanner: drives token transactions, predicts every
// closed document and checks each result transaction against that prediction.
// Depends on pds_pkg, the channel interfaces in pds_if.sv and the scanner RTL.
`timescale 1ns / 100ps

module tb_top;

	// Cycles without any transaction on either channel before the run is declared hung.
	// The longest legal quiet stretch is the forced output hold-off.
	localparam int unsigned WATCHDOG_LIMIT = 5000;
	// Cycles to let pass after the last expected result before touching the registers.
	// Covers the output register plus the four-entry record queue with margin.
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned MAX_REPORTED = 10;
	localparam int unsigned ITEMS_PER_PHASE = 500;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned MAX_SEND_GAP = 40;

	// Register indexes that decode to nothing; writes there must leave the block alone.
	localparam logic [pds_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [pds_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic [pds_pkg::TOK_W-1:0] end_offset;
		logic [pds_pkg::ROW_W-1:0] doc_length;
		logic [pds_pkg::ROW_W-1:0] longest_so_far;
		logic [pds_pkg::TOK_W-1:0] doc_count;
		logic                      boundary_seen;
		logic                      final_result;
	} doc_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           wr_en;
	logic [pds_pkg::CFG_IDX_W-1:0]  wr_index;
	logic [pds_pkg::CFG_DATA_W-1:0] wr_data;

	pds_token_if  tok_bus();
	pds_result_if res_bus();

	packed_document_boundary_scanner uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.tokens   (tok_bus),
		.results  (res_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Shadow copy of the configuration registers, updated when a write lands.
	logic [pds_pkg::ROW_W-1:0] cfg_row_len;
	logic                      cfg_multimodal;

	// Shadow copy of the scanner's batch state.
	logic [pds_pkg::POS_W-1:0] last_pos;
	logic [pds_pkg::ROW_W-1:0] column;
	logic [pds_pkg::ROW_W-1:0] doc_begin;
	logic [pds_pkg::TOK_W-1:0] tokens_taken;
	logic [pds_pkg::ROW_W-1:0] longest_len;
	logic [pds_pkg::TOK_W-1:0] docs_closed;
	logic                      boundary_flag;

	// Documents predicted to close, oldest first, waiting for their result transaction.
	doc_result_t expected_docs[$];

	int unsigned tokens_accepted;
	int unsigned docs_checked;
	int unsigned batches_closed;
	int unsigned config_writes;
	int unsigned failures;

	// Idling knobs, in percent per cycle, plus a countdown that forces the receiver to
	// refuse results for a long stretch.
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_off_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	function automatic void clear_batch_state();
		last_pos = '0;
		tokens_taken = '0;
		longest_len = '0;
		docs_closed = '0;
		boundary_flag = 1'b0;
	endfunction

	// Records one closed document. The running maximum and the document count are
	// updated first, so the result already includes the document it describes. The
	// count saturates at the token limit just as the token counter does.
	function automatic void close_document(logic [pds_pkg::TOK_W-1:0] end_at,
		logic [pds_pkg::ROW_W-1:0] len, logic fin);
		doc_result_t doc;
		if (len > longest_len)
			longest_len = len;
		if (docs_closed < pds_pkg::MAX_TOKENS)
			docs_closed = docs_closed + 1'b1;
		doc.end_offset = end_at;
		doc.doc_length = len;
		doc.longest_so_far = longest_len;
		doc.doc_count = docs_closed;
		doc.boundary_seen = boundary_flag;
		doc.final_result = fin;
		expected_docs = {expected_docs, doc};
	endfunction

	// Advances the shadow state by one accepted token and queues the documents it closes:
	// an in-row boundary result first, then a row-end result.
	function automatic void predict_token(logic [pds_pkg::POS_W-1:0] pos, logic last);
		logic [pds_pkg::ROW_W:0] eff_len;
		longint                  pos_step;
		logic                    brk;
		// A row length of zero behaves as one; anything past the row limit is clipped.
		eff_len = {1'b0, cfg_row_len};
		if (eff_len == '0)
			eff_len = (pds_pkg::ROW_W+1)'(1);
		if (eff_len > {1'b0, pds_pkg::MAX_ROW})
			eff_len = {1'b0, pds_pkg::MAX_ROW};
		// The first token of a row is never compared with the one before it. The step is
		// taken wider than the positions, so the wrap from the largest to the smallest
		// position is a large negative step and not a step of one.
		if (column != 0) begin
			pos_step = longint'($signed(pos)) - longint'($signed(last_pos));
			brk = cfg_multimodal ? (pos_step < 0) : (pos_step != 1);
			if (brk) begin
				boundary_flag = 1'b1;
				close_document(tokens_taken, column - doc_begin, 1'b0);
				doc_begin = column;
			end
		end
		last_pos = pos;
		if (tokens_taken < pds_pkg::MAX_TOKENS)
			tokens_taken = tokens_taken + 1'b1;
		column = column + 1'b1;
		// A batch end closes the row wherever it falls, and that result is the final one.
		if ({1'b0, column} >= eff_len || last) begin
			close_document(tokens_taken, column - doc_begin, last);
			column = '0;
			doc_begin = '0;
		end
		if (last) begin
			clear_batch_state();
			batches_closed++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Driving
	// ------------------------------------------------------------------

	// Offers one token transaction, after a random idle gap, and returns in the time step
	// of the clock edge that accepted it.
	task automatic send_token(logic [pds_pkg::POS_W-1:0] pos, logic last);
		int unsigned gap;
		gap = 0;
		while (gap < MAX_SEND_GAP && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			tok_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tok_bus.valid <= 1'b1;
		tok_bus.position_id <= pos;
		tok_bus.batch_end <= last;
		do
			@(posedge clk);
		while (tok_bus.ready !== 1'b1);
		predict_token(pos, last);
		tokens_accepted++;
	endtask

	// Stops offering tokens and waits until every predicted document has come out, then
	// gives a token that closed nothing time to leave the pipeline as well.
	task automatic wait_idle();
		tok_bus.valid <= 1'b0;
		while (expected_docs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register. Only called once the scanner is idle.
	task automatic write_register(logic [pds_pkg::CFG_IDX_W-1:0] index,
		logic [pds_pkg::CFG_DATA_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= index;
		wr_data <= data;
		@(posedge clk);
		wr_en <= 1'b0;
		if (index == pds_pkg::REG_ROW_LENGTH)
			cfg_row_len = data[pds_pkg::ROW_W-1:0];
		else if (index == pds_pkg::REG_MULTIMODAL)
			cfg_multimodal = data[0];
		config_writes++;
		@(posedge clk);
	endtask

	// The receiver either obeys a forced hold-off or stalls at random at the set rate.
	initial begin : result_receiver
		res_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				hold_off_left--;
				res_bus.ready <= 1'b0;
			end else begin
				res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	function automatic void report_failure(string what, doc_result_t got, doc_result_t want);
		failures++;
		if (failures <= MAX_REPORTED) begin
			$display("%0t ns %s", $time, what);
			$display("  expected end=%0d len=%0d max=%0d count=%0d boundary=%0b final=%0b",
				want.end_offset, want.doc_length, want.longest_so_far, want.doc_count,
				want.boundary_seen, want.final_result);
			$display("  actual   end=%0d len=%0d max=%0d count=%0d boundary=%0b final=%0b",
				got.end_offset, got.doc_length, got.longest_so_far, got.doc_count,
				got.boundary_seen, got.final_result);
		end
	endfunction

	// Every result transaction is matched against the oldest predicted document.
	always @(posedge clk) begin : check_results
		doc_result_t got;
		doc_result_t want;
		if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			got.end_offset = res_bus.end_offset;
			got.doc_length = res_bus.doc_length;
			got.longest_so_far = res_bus.longest_so_far;
			got.doc_count = res_bus.doc_count;
			got.boundary_seen = res_bus.boundary_seen;
			got.final_result = res_bus.final_result;
			docs_checked++;
			if (expected_docs.size() == 0) begin
				report_failure("result transaction with no document expected", got, '0);
			end else begin
				want = expected_docs.pop_front();
				if (got.end_offset !== want.end_offset || got.doc_length !== want.doc_length
					|| got.longest_so_far !== want.longest_so_far
					|| got.doc_count !== want.doc_count
					|| got.boundary_seen !== want.boundary_seen
					|| got.final_result !== want.final_result)
					report_failure("result transaction differs from prediction", got, want);
			end
		end
	end

	// A run that stops moving on both channels is ended here as a failure.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((tok_bus.valid === 1'b1 && tok_bus.ready === 1'b1)
				|| (res_bus.valid === 1'b1 && res_bus.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("Watchdog: no transaction for %0d cycles, %0d documents still expected",
			WATCHDOG_LIMIT, expected_docs.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly short rows so batches close often, sometimes zero, now and then longer rows.
	function automatic logic [pds_pkg::CFG_DATA_W-1:0] pick_row_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		else if (r < 75)
			return pds_pkg::CFG_DATA_W'($urandom_range(1, 8));
		else if (r < 95)
			return pds_pkg::CFG_DATA_W'($urandom_range(9, 40));
		else
			return pds_pkg::CFG_DATA_W'($urandom_range(41, 200));
	endfunction

	// Position streams look like packed documents: runs counting up by one, restarts at
	// zero, with repeats, small drops, small skips and the odd arbitrary value mixed in.
	function automatic logic [pds_pkg::POS_W-1:0] next_position(logic [pds_pkg::POS_W-1:0] prev,
		logic row_start);
		int unsigned r;
		r = $urandom_range(99);
		if (row_start && r < 50)
			return '0;
		if (r < 70)
			return prev + 1'b1;
		else if (r < 80)
			return '0;
		else if (r < 86)
			return prev;
		else if (r < 92)
			return prev - pds_pkg::POS_W'($urandom_range(1, 5));
		else if (r < 96)
			return prev + pds_pkg::POS_W'($urandom_range(2, 5));
		else
			return $urandom();
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Hand-picked tokens: position extremes, both modes, the zero and largest row
	// lengths, a batch end in the middle of a row and writes to unused indexes.
	task automatic test_directed_cases();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		// After reset the row length is one, so every token is a document of its own.
		send_token(32'h0000_0000, 1'b0);
		send_token(32'h7FFF_FFFF, 1'b0);
		send_token(32'h8000_0000, 1'b1);
		wait_idle();
		// A zero row length behaves as one.
		write_register(pds_pkg::REG_ROW_LENGTH, 17'd0);
		send_token(32'hFFFF_FFFF, 1'b0);
		send_token(32'h0000_0005, 1'b1);
		wait_idle();
		// Normal mode: a skip, a repeat and the wrap from the largest position to the
		// smallest all break. The next row starts lower without a comparison, and the
		// batch then ends in the middle of that row.
		write_register(pds_pkg::REG_ROW_LENGTH, 17'd8);
		send_token(32'd0, 1'b0);
		send_token(32'd1, 1'b0);
		send_token(32'd2, 1'b0);
		send_token(32'd5, 1'b0);
		send_token(32'd5, 1'b0);
		send_token(32'h7FFF_FFFF, 1'b0);
		send_token(32'h8000_0000, 1'b0);
		send_token(32'h8000_0001, 1'b0);
		send_token(32'h7FFF_FFFE, 1'b0);
		send_token(32'h7FFF_FFFF, 1'b0);
		send_token(32'd100, 1'b1);
		wait_idle();
		// Multimodal mode: repeats and rises continue a document, only a drop breaks it.
		// The batch end lands on a row end here.
		write_register(pds_pkg::REG_MULTIMODAL, 17'd1);
		write_register(pds_pkg::REG_ROW_LENGTH, 17'd5);
		send_token(32'h8000_0000, 1'b0);
		send_token(32'h8000_0000, 1'b0);
		send_token(32'd7, 1'b0);
		send_token(32'd3, 1'b0);
		send_token(32'h7FFF_FFFF, 1'b1);
		wait_idle();
		// Writes to unused indexes change nothing: the row length stays five and the mode
		// stays multimodal, so the repeat below does not break and no row end appears.
		write_register(REG_SPARE_2, 17'd2);
		write_register(REG_SPARE_3, 17'd0);
		send_token(32'd4, 1'b0);
		send_token(32'd4, 1'b0);
		send_token(32'd9, 1'b1);
		wait_idle();
		// The largest legal row length, and a mode write where only bit zero counts.
		write_register(pds_pkg::REG_ROW_LENGTH, pds_pkg::MAX_ROW);
		write_register(pds_pkg::REG_MULTIMODAL, 17'h1FFFE);
		send_token(32'd10, 1'b0);
		send_token(32'd12, 1'b1);
		wait_idle();
	endtask

	// Shrinking the row length under a row that already holds more tokens makes the very
	// next token end the row.
	task automatic test_row_length_change();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_register(pds_pkg::REG_ROW_LENGTH, 17'd6);
		send_token(32'd0, 1'b0);
		send_token(32'd1, 1'b0);
		send_token(32'd2, 1'b0);
		send_token(32'd3, 1'b0);
		wait_idle();
		write_register(pds_pkg::REG_ROW_LENGTH, 17'd3);
		send_token(32'd4, 1'b0);
		send_token(32'd0, 1'b0);
		send_token(32'd1, 1'b0);
		wait_idle();
		// The row now holds exactly as many tokens as the new length.
		write_register(pds_pkg::REG_ROW_LENGTH, 17'd2);
		send_token(32'd2, 1'b1);
		wait_idle();
	endtask

	// Random batches under one idling profile. Each batch gets a fresh configuration,
	// usually a whole number of rows, sometimes cut short by an early batch end, and
	// now and then a row length change half way through.
	task automatic test_random_traffic(int unsigned send_pct, int unsigned recv_pct,
		int unsigned n_items);
		int unsigned                    sent;
		int unsigned                    row_tokens;
		int unsigned                    batch_tokens;
		int unsigned                    k;
		logic [pds_pkg::POS_W-1:0]      pos;
		logic [pds_pkg::CFG_DATA_W-1:0] len_value;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < n_items) begin
			wait_idle();
			len_value = pick_row_length();
			write_register(pds_pkg::REG_ROW_LENGTH, len_value);
			if ($urandom_range(1) == 1)
				write_register(pds_pkg::REG_MULTIMODAL,
					pds_pkg::CFG_DATA_W'($urandom_range(1)));
			row_tokens = (len_value == 0) ? 1 : int'(len_value);
			batch_tokens = row_tokens * $urandom_range(1, 4);
			if ($urandom_range(9) == 0)
				batch_tokens = $urandom_range(1, batch_tokens);
			pos = $urandom();
			for (k = 0; k < batch_tokens; k++) begin
				if (k == batch_tokens / 2 && $urandom_range(9) == 0) begin
					wait_idle();
					write_register(pds_pkg::REG_ROW_LENGTH, pick_row_length());
				end
				pos = next_position(pos, column == 0);
				send_token(pos, k == batch_tokens - 1);
				sent++;
			end
		end
		wait_idle();
	endtask

	// The receiver refuses results for a long stretch while tokens keep coming, so the
	// output register and the record queue fill and the token channel must stall.
	task automatic test_output_backpressure();
		int unsigned k;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		write_register(pds_pkg::REG_ROW_LENGTH, 17'd2);
		write_register(pds_pkg::REG_MULTIMODAL, 17'd0);
		hold_off_left = HOLD_OFF_CYCLES;
		for (k = 0; k < 80; k++)
			send_token($urandom(), k == 79);
		wait_idle();
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin : main_sequence
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= pds_pkg::REG_ROW_LENGTH;
		wr_data <= '0;
		tok_bus.valid <= 1'b0;
		tok_bus.position_id <= '0;
		tok_bus.batch_end <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_left = 0;
		tokens_accepted = 0;
		docs_checked = 0;
		batches_closed = 0;
		config_writes = 0;
		failures = 0;
		// Reset values of the registers and of the batch state.
		cfg_row_len = 17'd1;
		cfg_multimodal = 1'b0;
		column = '0;
		doc_begin = '0;
		clear_batch_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_row_length_change();
		// Idling profiles: none, sender gaps, receiver stalls, then a little of both.
		test_random_traffic(0, 0, ITEMS_PER_PHASE);
		test_random_traffic(63, 0, ITEMS_PER_PHASE);
		test_random_traffic(0, 63, ITEMS_PER_PHASE);
		test_random_traffic(8, 8, ITEMS_PER_PHASE);
		test_output_backpressure();

		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_idle();
		if (expected_docs.size() != 0) begin
			$display("%0d predicted documents never came out", expected_docs.size());
			failures += expected_docs.size();
		end
		$display("Run covered %0d token and %0d result transactions in %0d batches, %0d writes.",
			tokens_accepted, docs_checked, batches_closed, config_writes);
		$display("Both modes, all row length rules, four idling profiles and a long stall %s%0d",
			"were exercised; failures: ", failures);
		if (failures == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
